// ----- rtl/core/idll_pkg.sv -----
// ----------------------------------------------------------------------------
// idll_pkg
// Types and constants shared by the indexed doubly linked list unit.
// ----------------------------------------------------------------------------
package idll_pkg;

   localparam int POOL_NODES = 1024;
   localparam int VALUE_BITS = 32;
   localparam int NODE_BITS  = 10;
   localparam int ADDR_BITS  = $clog2(POOL_NODES);
   localparam int CNT_BITS   = $clog2(POOL_NODES + 1);

   localparam logic [NODE_BITS-1:0] HEAD_NODE = NODE_BITS'(0);
   localparam logic [NODE_BITS-1:0] TAIL_NODE = NODE_BITS'(1);

   typedef enum logic [1:0] {
      OP_INS_RIGHT = 2'd0,
      OP_INS_LEFT  = 2'd1,
      OP_DELETE    = 2'd2,
      OP_READ      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                        op;
      logic [NODE_BITS-1:0]          node_index;
      logic signed [VALUE_BITS-1:0]  new_value;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic [NODE_BITS-1:0]          assigned_node;
      logic signed [VALUE_BITS-1:0]  node_value;
      logic [NODE_BITS-1:0]          next_node;
      logic [NODE_BITS-1:0]          prev_node;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      req_type               req;
      status_type            status;
      logic [NODE_BITS-1:0]  assigned_node;
   } work_type;

   typedef struct packed {
      logic      valid;
      work_type  word;
   } work_port_type;

endpackage

// ----- rtl/core/idll_front.sv -----
// ----------------------------------------------------------------------------
// idll_front
// Accepts words, checks them against the allocation count and the sentinels, and queues them.
// ----------------------------------------------------------------------------
module idll_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  idll_pkg::req_type        req_word,
   output idll_pkg::work_port_type  work_out,
   input  logic                     work_take
);

   logic [idll_pkg::CNT_BITS-1:0] alloc_ff, alloc_in;
   idll_pkg::work_type            q_ff [2];
   logic                          wr_ptr_ff, wr_ptr_in;
   logic                          rd_ptr_ff, rd_ptr_in;
   logic [1:0]                    count_ff, count_in;
   logic                          push;
   idll_pkg::work_type            cls;
   logic [idll_pkg::CNT_BITS-1:0] idx_ext;

   assign req_full = (count_ff == 2'd2);
   assign push     = req_push && !req_full;
   assign idx_ext  = idll_pkg::CNT_BITS'(req_word.node_index);

   always_comb begin
      cls               = '0;
      cls.req           = req_word;
      cls.status        = idll_pkg::ST_OK;
      cls.assigned_node = '0;
      alloc_in          = alloc_ff;
      if (idx_ext >= alloc_ff) begin
         cls.status = idll_pkg::ST_BAD;
      end else begin
         unique case (req_word.op)
            idll_pkg::OP_READ: begin
               cls.status = idll_pkg::ST_OK;
            end
            idll_pkg::OP_DELETE: begin
               if (req_word.node_index == idll_pkg::HEAD_NODE ||
                   req_word.node_index == idll_pkg::TAIL_NODE) begin
                  cls.status = idll_pkg::ST_BAD;
               end
            end
            default: begin
               // inserts: no splice outside the sentinels
               if ((req_word.op == idll_pkg::OP_INS_RIGHT &&
                    req_word.node_index == idll_pkg::TAIL_NODE) ||
                   (req_word.op == idll_pkg::OP_INS_LEFT &&
                    req_word.node_index == idll_pkg::HEAD_NODE)) begin
                  cls.status = idll_pkg::ST_BAD;
               end else if (alloc_ff == idll_pkg::CNT_BITS'(idll_pkg::POOL_NODES)) begin
                  cls.status = idll_pkg::ST_FULL;
               end else begin
                  cls.assigned_node = alloc_ff[idll_pkg::NODE_BITS-1:0];
                  if (push) begin
                     alloc_in = alloc_ff + idll_pkg::CNT_BITS'(1);
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = work_take ? !rd_ptr_ff : rd_ptr_ff;
      case ({push, work_take})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= idll_pkg::CNT_BITS'(2);
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         alloc_ff  <= alloc_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   assign work_out.valid = (count_ff != 2'd0);
   assign work_out.word  = q_ff[rd_ptr_ff];

endmodule

// ----- rtl/core/idll_back.sv -----
// ----------------------------------------------------------------------------
// idll_back
// Carries out link reads and splices on the node memories, queues results.
// ----------------------------------------------------------------------------
module idll_back (
   input  logic                     clock,
   input  logic                     reset,
   input  idll_pkg::work_port_type  work_in,
   output logic                     work_take,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output idll_pkg::rsp_type        rsp_word
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_LINK = 3'b100
   } state_type;

   localparam int AB = idll_pkg::ADDR_BITS;
   localparam int NB = idll_pkg::NODE_BITS;
   localparam int VB = idll_pkg::VALUE_BITS;

   logic [NB-1:0] next_mem [idll_pkg::POOL_NODES];
   logic [NB-1:0] prev_mem [idll_pkg::POOL_NODES];
   logic [VB-1:0] val_mem  [idll_pkg::POOL_NODES];

   state_type          state_ff, state_in;
   idll_pkg::work_type cur_ff, cur_in;
   logic [NB-1:0]      p_ff, p_in, n_ff, n_in;
   logic [NB-1:0]      next_rd_ff, prev_rd_ff;
   logic [VB-1:0]      val_rd_ff;
   logic [1:0]         next_ok_ff, next_ok_in;
   logic [1:0]         prev_ok_ff, prev_ok_in;

   logic               rd_en;
   logic [AB-1:0]      rd_addr;
   logic               nw_en, pw_en, vw_en;
   logic [AB-1:0]      nw_addr, pw_addr, vw_addr;
   logic [NB-1:0]      nw_data, pw_data;
   logic [VB-1:0]      vw_data;
   logic [NB-1:0]      link_next, link_prev;
   logic               sentinel;

   idll_pkg::rsp_type  rq_ff [2];
   logic               rq_wr_ff, rq_rd_ff;
   logic [1:0]         rq_count_ff, rq_count_in;
   logic               rs_push;
   idll_pkg::rsp_type  rs_word;

   assign work_take = (state_ff == S_IDLE) && work_in.valid && (rq_count_ff != 2'd2);
   assign rd_en     = work_take && (work_in.word.status == idll_pkg::ST_OK);
   assign rd_addr   = work_in.word.req.node_index[AB-1:0];

   // sentinel entries read as an empty list (next = tail, prev = head) until first written
   always_comb begin
      sentinel  = (cur_ff.req.node_index[NB-1:1] == '0);
      link_next = next_rd_ff;
      link_prev = prev_rd_ff;
      if (sentinel && !next_ok_ff[cur_ff.req.node_index[0]]) begin
         link_next = idll_pkg::TAIL_NODE;
      end
      if (sentinel && !prev_ok_ff[cur_ff.req.node_index[0]]) begin
         link_prev = idll_pkg::HEAD_NODE;
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      nw_en    = 1'b0;
      pw_en    = 1'b0;
      vw_en    = 1'b0;
      nw_addr  = '0;
      pw_addr  = '0;
      vw_addr  = cur_ff.assigned_node[AB-1:0];
      nw_data  = '0;
      pw_data  = '0;
      vw_data  = cur_ff.req.new_value;
      rs_push  = 1'b0;
      rs_word  = '0;
      rs_word.status = idll_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (work_take) begin
               if (work_in.word.status != idll_pkg::ST_OK) begin
                  rs_push        = 1'b1;
                  rs_word.status = work_in.word.status;
               end else begin
                  cur_in   = work_in.word;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            case (cur_ff.req.op)
               idll_pkg::OP_READ: begin
                  rs_push            = 1'b1;
                  rs_word.node_value = cur_ff.req.new_value;
                  rs_word.node_value = val_rd_ff;
                  rs_word.next_node  = link_next;
                  rs_word.prev_node  = link_prev;
                  state_in           = S_IDLE;
               end
               idll_pkg::OP_DELETE: begin
                  nw_en    = 1'b1;
                  nw_addr  = link_prev[AB-1:0];
                  nw_data  = link_next;
                  pw_en    = 1'b1;
                  pw_addr  = link_next[AB-1:0];
                  pw_data  = link_prev;
                  rs_push  = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  // first half of a splice: outer neighbors point at the new node
                  if (cur_ff.req.op == idll_pkg::OP_INS_RIGHT) begin
                     p_in = cur_ff.req.node_index;
                     n_in = link_next;
                  end else begin
                     p_in = link_prev;
                     n_in = cur_ff.req.node_index;
                  end
                  nw_en    = 1'b1;
                  nw_addr  = p_in[AB-1:0];
                  nw_data  = cur_ff.assigned_node;
                  pw_en    = 1'b1;
                  pw_addr  = n_in[AB-1:0];
                  pw_data  = cur_ff.assigned_node;
                  vw_en    = 1'b1;
                  state_in = S_LINK;
               end
            endcase
         end
         S_LINK: begin
            nw_en                 = 1'b1;
            nw_addr               = cur_ff.assigned_node[AB-1:0];
            nw_data               = n_ff;
            pw_en                 = 1'b1;
            pw_addr               = cur_ff.assigned_node[AB-1:0];
            pw_data               = p_ff;
            rs_push               = 1'b1;
            rs_word.assigned_node = cur_ff.assigned_node;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      next_ok_in = next_ok_ff;
      prev_ok_in = prev_ok_ff;
      if (nw_en && nw_addr[AB-1:1] == '0) begin
         next_ok_in[nw_addr[0]] = 1'b1;
      end
      if (pw_en && pw_addr[AB-1:1] == '0) begin
         prev_ok_in[pw_addr[0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         next_ok_ff <= 2'b00;
         prev_ok_ff <= 2'b00;
      end else begin
         state_ff   <= state_in;
         next_ok_ff <= next_ok_in;
         prev_ok_ff <= prev_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      p_ff   <= p_in;
      n_ff   <= n_in;
   end

   always_ff @(posedge clock) begin
      if (nw_en) begin
         next_mem[nw_addr] <= nw_data;
      end
      if (rd_en) begin
         next_rd_ff <= next_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pw_en) begin
         prev_mem[pw_addr] <= pw_data;
      end
      if (rd_en) begin
         prev_rd_ff <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (vw_en) begin
         val_mem[vw_addr] <= vw_data;
      end
      if (rd_en) begin
         val_rd_ff <= val_mem[rd_addr];
      end
   end

   // result queue
   always_comb begin
      case ({rs_push, rsp_pop && !rsp_empty})
         2'b10:   rq_count_in = rq_count_ff + 2'd1;
         2'b01:   rq_count_in = rq_count_ff - 2'd1;
         default: rq_count_in = rq_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         rq_count_ff <= rq_count_in;
         if (rs_push) begin
            rq_wr_ff <= !rq_wr_ff;
         end
         if (rsp_pop && !rsp_empty) begin
            rq_rd_ff <= !rq_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rs_push) begin
         rq_ff[rq_wr_ff] <= rs_word;
      end
   end

   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp_word  = rq_ff[rq_rd_ff];

endmodule

// ----- rtl/core/indexed_doubly_linked_list_unit.sv -----
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_unit
// Node pool holding one doubly linked list between head and tail sentinels.
// ----------------------------------------------------------------------------
//   channel   ports                          accepted when
//   request   req_push req_full req_word     req_push && !req_full
//   response  rsp_empty rsp_pop rsp_word     rsp_pop && !rsp_empty
//
// The back end answers a rejected word in S_IDLE, a read or delete in S_READ and
// an insert in S_LINK after S_READ: each link memory has one write port and an
// insert writes two entries of it after reading the neighbor link.
// Reset empties the queues and sets the allocation count to two; no clearing
// pass. Either side may stall: two-word queues sit before and after the back end.
module indexed_doubly_linked_list_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  idll_pkg::req_type  req_word,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output idll_pkg::rsp_type  rsp_word
);

   idll_pkg::work_port_type work;
   logic                    work_take;

   idll_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .work_out  (work),
      .work_take (work_take)
   );

   idll_back u_back (
      .clock     (clock),
      .reset     (reset),
      .work_in   (work),
      .work_take (work_take),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word)
   );

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      work_take |-> work.valid)
      else $error("back end took a word from an empty queue");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.status != idll_pkg::ST_OK) |->
      (rsp_word.assigned_node == '0 && rsp_word.node_value == '0 &&
       rsp_word.next_node == '0 && rsp_word.prev_node == '0))
      else $error("failed word carries data");

   a_assigned_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.assigned_node != '0) |->
      (rsp_word.status == idll_pkg::ST_OK &&
       rsp_word.assigned_node != idll_pkg::TAIL_NODE))
      else $error("assigned node is a sentinel");

   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule
